/* hdl/sscw_pkg.sv */
// ----------------------------------------------------------------------------
// sscw_pkg
// Shared constants, types and font tables for the seven-segment char writer.
// ----------------------------------------------------------------------------
package sscw_pkg;

	localparam int CELL_W = 4;
	localparam int SEG_W  = 7;
	localparam int CHAR_W = 8;

	localparam logic [CELL_W-1:0] POS_START = 4'd10;
	localparam logic [CELL_W-1:0] POS_FULL  = 4'd15;
	localparam logic [CELL_W-1:0] CELL_LAST = 4'd10;

	localparam logic [CHAR_W-1:0] CASE_MASK  = 8'hdf;
	localparam logic [CHAR_W-1:0] CHAR_CR    = 8'h0d;
	localparam logic [CHAR_W-1:0] CHAR_LF    = 8'h0a;
	localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;

	typedef struct packed {
		logic             valid;
		logic             pair;
		logic [SEG_W-1:0] seg0;
		logic [SEG_W-1:0] seg1;
	} glyph_t;

	// controller -> datapath
	typedef struct packed {
		logic load;
		logic rewind;
		logic clr_start;
		logic emit_clr;
		logic emit_first;
		logic emit_second;
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic in_cr;
		logic in_lf;
		logic in_glyph;
		logic pair_pending;
		logic pos_full;
		logic pos_zero;
		logic clr_done;
		logic out_free;
	} sts_t;

	function automatic logic [CELL_W-1:0] cell_order(input logic [CELL_W-1:0] p);
		logic [CELL_W-1:0] r;
		case (p)
			4'd0:    r = 4'd9;
			4'd1:    r = 4'd4;
			4'd2:    r = 4'd8;
			4'd3:    r = 4'd3;
			4'd4:    r = 4'd7;
			4'd5:    r = 4'd2;
			4'd6:    r = 4'd10;
			4'd7:    r = 4'd6;
			4'd8:    r = 4'd1;
			4'd9:    r = 4'd5;
			4'd10:   r = 4'd0;
			default: r = 4'd0;
		endcase
		return r;
	endfunction

	function automatic glyph_t glyph_decode(input logic [CHAR_W-1:0] c);
		glyph_t           g;
		logic [CHAR_W-1:0] uc;
		uc = c & CASE_MASK;
		g  = '{valid: 1'b1, pair: 1'b0, seg0: 7'h00, seg1: 7'h00};
		case (uc)
			8'h41: g.seg0 = 7'h77;
			8'h42: g.seg0 = 7'h7c;
			8'h43: g.seg0 = 7'h39;
			8'h44: g.seg0 = 7'h5e;
			8'h45: g.seg0 = 7'h79;
			8'h46: g.seg0 = 7'h71;
			8'h47: g.seg0 = 7'h6f;
			8'h48: g.seg0 = 7'h74;
			8'h49: g.seg0 = 7'h30;
			8'h4a: g.seg0 = 7'h1e;
			8'h4b: begin
				g.pair = 1'b1; g.seg0 = 7'h06; g.seg1 = 7'h64;
			end
			8'h4c: g.seg0 = 7'h38;
			8'h4d: begin
				g.pair = 1'b1; g.seg0 = 7'h33; g.seg1 = 7'h27;
			end
			8'h4e: g.seg0 = 7'h54;
			8'h4f: g.seg0 = 7'h5c;
			8'h50: g.seg0 = 7'h73;
			8'h51: g.seg0 = 7'h67;
			8'h52: g.seg0 = 7'h50;
			8'h53: g.seg0 = 7'h6d;
			8'h54: g.seg0 = 7'h78;
			8'h55: g.seg0 = 7'h1c;
			8'h56: g.seg0 = 7'h3c;
			8'h57: begin
				g.pair = 1'b1; g.seg0 = 7'h3c; g.seg1 = 7'h1e;
			end
			8'h58: g.seg0 = 7'h76;
			8'h59: g.seg0 = 7'h66;
			8'h5a: g.seg0 = 7'h5b;
			default: begin
				case (c)
					8'h30:      g.seg0 = 7'h3f;
					8'h31:      g.seg0 = 7'h06;
					8'h32:      g.seg0 = 7'h5b;
					8'h33:      g.seg0 = 7'h4f;
					8'h34:      g.seg0 = 7'h66;
					8'h35:      g.seg0 = 7'h6d;
					8'h36:      g.seg0 = 7'h7d;
					8'h37:      g.seg0 = 7'h07;
					8'h38:      g.seg0 = 7'h7f;
					8'h39:      g.seg0 = 7'h6f;
					CHAR_SPACE: g.seg0 = 7'h00;
					default:    g.valid = 1'b0;
				endcase
			end
		endcase
		return g;
	endfunction

endpackage

/* hdl/sscw_char_if.sv */
// ----------------------------------------------------------------------------
// sscw_char_if
// Valid/ready channel carrying one character byte per beat.
// ----------------------------------------------------------------------------
interface sscw_char_if;
	logic       valid;
	logic       ready;
	logic [7:0] char_code;

	modport source (output valid, output char_code, input ready);
	modport sink   (input valid, input char_code, output ready);
endinterface

/* hdl/sscw_cell_if.sv */
// ----------------------------------------------------------------------------
// sscw_cell_if
// Valid/ready channel carrying one display cell write per beat.
// ----------------------------------------------------------------------------
interface sscw_cell_if;
	logic       valid;
	logic       ready;
	logic [3:0] cell_index;
	logic [6:0] segments;
	logic       last;

	modport source (output valid, output cell_index, output segments, output last,
		input ready);
	modport sink   (input valid, input cell_index, input segments, input last,
		output ready);
endinterface

/* hdl/seven_segment_char_writer.sv */
// ----------------------------------------------------------------------------
// seven_segment_char_writer
// Turns ASCII characters into seven-segment display cell writes.
// ----------------------------------------------------------------------------
// Flow: an accepted character sends the controller to ST_FIRST or ST_CLEAR; write
//   beats are registered, one per cycle unless the output stalls. No new character
//   is taken until its writes are issued: one (letter, digit, space, or K/M/W with
//   one slot left), two (K, M, W), eleven (CR), none (LF, ignored code, full display).
// Reset: arst_n clears the controller and output valid and sets the write
//   pointer to cell slot 10; no clearing sweep is needed.
module seven_segment_char_writer (
	input logic         clk,
	input logic         arst_n,
	sscw_char_if.sink   chr,
	sscw_cell_if.source wr
);
	import sscw_pkg::*;

	cmd_t cmd;
	sts_t sts;

	sscw_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (chr.valid),
		.in_ready (chr.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	sscw_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.char_code  (chr.char_code),
		.cmd        (cmd),
		.sts        (sts),
		.out_valid  (wr.valid),
		.out_ready  (wr.ready),
		.cell_index (wr.cell_index),
		.segments   (wr.segments),
		.last       (wr.last)
	);

endmodule

/* hdl/sscw_dp.sv */
// ----------------------------------------------------------------------------
// sscw_dp
// Datapath: glyph decode, write pointer, clear counter and output register.
// ----------------------------------------------------------------------------
module sscw_dp (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [sscw_pkg::CHAR_W-1:0]   char_code,
	input  sscw_pkg::cmd_t                cmd,
	output sscw_pkg::sts_t                sts,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [sscw_pkg::CELL_W-1:0]   cell_index,
	output logic [sscw_pkg::SEG_W-1:0]    segments,
	output logic                          last
);
	import sscw_pkg::*;

	glyph_t            glyph;
	logic [CELL_W-1:0] pos_q;
	logic [CELL_W-1:0] cnt_q;
	logic [CELL_W-1:0] pos_next;
	logic [SEG_W-1:0]  seg0_q;
	logic [SEG_W-1:0]  seg1_q;
	logic              pair_q;
	logic              out_valid_q;
	logic [CELL_W-1:0] cell_index_q;
	logic [SEG_W-1:0]  segments_q;
	logic              last_q;
	logic              emit;

	assign glyph    = glyph_decode(char_code);
	assign pos_next = (pos_q == '0) ? POS_FULL : pos_q - 4'd1;
	assign emit     = cmd.emit_clr | cmd.emit_first | cmd.emit_second;

	always_comb begin
		sts.in_cr        = (char_code == CHAR_CR);
		sts.in_lf        = (char_code == CHAR_LF);
		sts.in_glyph     = glyph.valid;
		sts.pair_pending = pair_q;
		sts.pos_full     = (pos_q > CELL_LAST);
		sts.pos_zero     = (pos_q == '0);
		sts.clr_done     = (cnt_q == CELL_LAST);
		sts.out_free     = !out_valid_q || out_ready;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q       <= POS_START;
			cnt_q       <= '0;
			pair_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load)
				pair_q <= glyph.pair;
			if (cmd.rewind)
				pos_q <= POS_START;
			else if (cmd.emit_first || cmd.emit_second)
				pos_q <= pos_next;
			if (cmd.clr_start)
				cnt_q <= '0;
			else if (cmd.emit_clr)
				cnt_q <= cnt_q + 4'd1;
			if (emit)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			seg0_q <= glyph.seg0;
			seg1_q <= glyph.seg1;
		end
		if (cmd.emit_clr) begin
			cell_index_q <= cell_order(cnt_q);
			segments_q   <= '0;
			last_q       <= (cnt_q == CELL_LAST);
		end else if (cmd.emit_first) begin
			cell_index_q <= cell_order(pos_q);
			segments_q   <= seg0_q;
			last_q       <= !pair_q || (pos_q == '0);
		end else if (cmd.emit_second) begin
			cell_index_q <= cell_order(pos_q);
			segments_q   <= seg1_q;
			last_q       <= 1'b1;
		end
	end

	assign out_valid  = out_valid_q;
	assign cell_index = cell_index_q;
	assign segments   = segments_q;
	assign last       = last_q;

endmodule

/* hdl/sscw_ctrl.sv */
// ----------------------------------------------------------------------------
// sscw_ctrl
// Controller: accepts a character and sequences the cell write beats.
// ----------------------------------------------------------------------------
module sscw_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  sscw_pkg::sts_t sts,
	output sscw_pkg::cmd_t cmd
);
	import sscw_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CLEAR,
		ST_FIRST,
		ST_SECOND
	} state_t;

	state_t state_q;
	logic   accept;

	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;

	always_comb begin
		cmd             = '0;
		cmd.load        = accept;
		cmd.rewind      = accept && (sts.in_cr || sts.in_lf);
		cmd.clr_start   = accept && sts.in_cr;
		cmd.emit_clr    = (state_q == ST_CLEAR)  && sts.out_free;
		cmd.emit_first  = (state_q == ST_FIRST)  && sts.out_free;
		cmd.emit_second = (state_q == ST_SECOND) && sts.out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (sts.in_cr)
							state_q <= ST_CLEAR;
						else if (!sts.in_lf && sts.in_glyph && !sts.pos_full)
							state_q <= ST_FIRST;
					end
				end
				ST_CLEAR: begin
					if (sts.out_free && sts.clr_done)
						state_q <= ST_IDLE;
				end
				ST_FIRST: begin
					if (sts.out_free) begin
						if (sts.pair_pending && !sts.pos_zero)
							state_q <= ST_SECOND;
						else
							state_q <= ST_IDLE;
					end
				end
				ST_SECOND: begin
					if (sts.out_free)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	a_emit_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.emit_clr, cmd.emit_first, cmd.emit_second}))
		else $error("more than one emit command");

	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit_clr || cmd.emit_first || cmd.emit_second) |-> sts.out_free)
		else $error("emit while output register occupied");

	a_write_not_full: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FIRST || state_q == ST_SECOND) |-> !sts.pos_full)
		else $error("glyph write with full display");

	a_second_pair: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SECOND) |-> sts.pair_pending)
		else $error("second write without pair glyph");

endmodule

/* verif/sscw_cell_write_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sscw_cell_write_checker
// Watches the character and cell write channels of the seven-segment char
// writer. Each accepted character beat is run through a local model of the
// font, case folding and write pointer, and the resulting cell writes are
// queued. Each accepted write beat is compared field by field with the
// oldest queued write. Failures, outstanding writes and beat counts go back
// to the testbench top.
// ----------------------------------------------------------------------------
module sscw_cell_write_checker (
	input  logic  clk,
	input  logic  arst_n,
	sscw_char_if  chr,
	sscw_cell_if  wr,
	output int    fail_count,
	output int    pending,
	output int    chars_seen,
	output int    writes_seen
);
	import sscw_pkg::*;

	localparam logic [CHAR_W-1:0] CHAR_A       = 8'h41;
	localparam logic [CHAR_W-1:0] CHAR_K       = 8'h4b;
	localparam logic [CHAR_W-1:0] CHAR_M       = 8'h4d;
	localparam logic [CHAR_W-1:0] CHAR_UPPER_W = 8'h57;
	localparam logic [CHAR_W-1:0] CHAR_Z       = 8'h5a;
	localparam logic [CHAR_W-1:0] CHAR_0       = 8'h30;
	localparam logic [CHAR_W-1:0] CHAR_9       = 8'h39;

	// K, M and W entries unused: drawn as two cells
	localparam logic [0:25][SEG_W-1:0] LETTER_SEGS = {
		7'h77, 7'h7c, 7'h39, 7'h5e, 7'h79, 7'h71, 7'h6f, 7'h74, 7'h30, 7'h1e,
		7'h00, 7'h38, 7'h00, 7'h54, 7'h5c, 7'h73, 7'h67, 7'h50, 7'h6d, 7'h78,
		7'h1c, 7'h3c, 7'h00, 7'h76, 7'h66, 7'h5b
	};
	localparam logic [0:9][SEG_W-1:0] DIGIT_SEGS = {
		7'h3f, 7'h06, 7'h5b, 7'h4f, 7'h66, 7'h6d, 7'h7d, 7'h07, 7'h7f, 7'h6f
	};
	localparam logic [0:10][CELL_W-1:0] SLOT_CELLS = {
		4'd9, 4'd4, 4'd8, 4'd3, 4'd7, 4'd2, 4'd10, 4'd6, 4'd1, 4'd5, 4'd0
	};

	typedef struct packed {
		logic [CELL_W-1:0] cell_idx;
		logic [SEG_W-1:0]  segs;
		logic              last;
	} cell_write_t;

	cell_write_t       pending_writes[$];
	cell_write_t       want;
	logic [CELL_W-1:0] write_slot;

	task automatic queue_char_writes(input logic [CHAR_W-1:0] c);
		logic [CHAR_W-1:0] folded;
		logic [SEG_W-1:0]  segs[2];
		cell_write_t       w[2];
		int                cells;
		int                n;
		int                i;
		folded  = c & CASE_MASK;
		segs[0] = '0;
		segs[1] = '0;
		cells   = 1;
		n       = 0;
		if (c == CHAR_CR) begin
			write_slot = POS_START;
			for (i = 0; i <= CELL_LAST; i++) begin
				w[0].cell_idx = SLOT_CELLS[i];
				w[0].segs     = '0;
				w[0].last     = (i == CELL_LAST);
				pending_writes.push_back(w[0]);
			end
		end else if (c == CHAR_LF) begin
			write_slot = POS_START;
		end else begin
			if (folded >= CHAR_A && folded <= CHAR_Z) begin
				case (folded)
					CHAR_K: begin
						cells = 2; segs[0] = 7'h06; segs[1] = 7'h64;
					end
					CHAR_M: begin
						cells = 2; segs[0] = 7'h33; segs[1] = 7'h27;
					end
					CHAR_UPPER_W: begin
						cells = 2; segs[0] = 7'h3c; segs[1] = 7'h1e;
					end
					default: segs[0] = LETTER_SEGS[folded - CHAR_A];
				endcase
			end else if (c >= CHAR_0 && c <= CHAR_9) begin
				segs[0] = DIGIT_SEGS[c - CHAR_0];
			end else if (c != CHAR_SPACE) begin
				cells = 0;
			end
			for (i = 0; i < cells; i++) begin
				// slots above the last one mean the display is full
				if (write_slot <= CELL_LAST) begin
					w[n].cell_idx = SLOT_CELLS[write_slot];
					w[n].segs     = segs[i];
					w[n].last     = 1'b0;
					n++;
					write_slot = (write_slot == '0) ? POS_FULL : write_slot - 1'b1;
				end
			end
			if (n > 0)
				w[n-1].last = 1'b1;
			for (i = 0; i < n; i++)
				pending_writes.push_back(w[i]);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			write_slot  = POS_START;
			pending_writes.delete();
			fail_count  = 0;
			pending     = 0;
			chars_seen  = 0;
			writes_seen = 0;
		end else begin
			if (wr.valid && wr.ready) begin
				writes_seen++;
				if (pending_writes.size() == 0) begin
					$error("unexpected write beat: cell_index %0d segments %h last %b",
						wr.cell_index, wr.segments, wr.last);
					fail_count++;
				end else begin
					want = pending_writes.pop_front();
					if (wr.cell_index !== want.cell_idx) begin
						$error("cell_index: expected %0d, got %0d", want.cell_idx,
							wr.cell_index);
						fail_count++;
					end
					if (wr.segments !== want.segs) begin
						$error("segments: expected %h, got %h", want.segs, wr.segments);
						fail_count++;
					end
					if (wr.last !== want.last) begin
						$error("last: expected %b, got %b", want.last, wr.last);
						fail_count++;
					end
				end
			end
			if (chr.valid && chr.ready) begin
				chars_seen++;
				queue_char_writes(chr.char_code);
			end
			pending = pending_writes.size();
		end
	end

endmodule

/* verif/tb_seven_segment_char_writer.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_seven_segment_char_writer
// Drives characters into the seven-segment char writer and stalls its write
// output at random. A directed run covers control codes, case folding, the
// two-cell letters and display overflow; random lines of printable glyphs
// ended by CR or LF follow, mixed with noise bytes. The checker module does
// prediction and comparison; this top gives the verdict.
// ----------------------------------------------------------------------------
module tb_seven_segment_char_writer;
	import sscw_pkg::*;

	localparam logic [CHAR_W-1:0] LOWER_BIT  = 8'h20;
	localparam int                LINE_ITEMS = 260;
	localparam int                HOLD_LEN   = 150;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	int fail_count;
	int pending;
	int chars_seen;
	int writes_seen;
	int src_idle_max = 0;
	int sink_idle_max = 0;
	int sink_hold = 0;
	int line_items = 0;

	sscw_char_if chr_bus ();
	sscw_cell_if wr_bus ();

	seven_segment_char_writer dut (
		.clk    (clk),
		.arst_n (arst_n),
		.chr    (chr_bus),
		.wr     (wr_bus)
	);

	sscw_cell_write_checker checker_i (
		.clk         (clk),
		.arst_n      (arst_n),
		.chr         (chr_bus),
		.wr          (wr_bus),
		.fail_count  (fail_count),
		.pending     (pending),
		.chars_seen  (chars_seen),
		.writes_seen (writes_seen)
	);

	always #2 clk = ~clk;

	task automatic send_char(input logic [CHAR_W-1:0] c);
		int gap;
		gap = $urandom_range(0, src_idle_max);
		repeat (gap) begin
			@(negedge clk);
			chr_bus.valid = 1'b0;
		end
		@(negedge clk);
		chr_bus.valid     = 1'b1;
		chr_bus.char_code = c;
		do @(posedge clk); while (!chr_bus.ready);
	endtask

	task automatic send_text(input string s);
		int i;
		for (i = 0; i < s.len(); i++)
			send_char(s[i]);
	endtask

	task automatic drain_writes();
		@(negedge clk);
		chr_bus.valid = 1'b0;
		while (pending != 0)
			@(negedge clk);
	endtask

	function automatic logic [CHAR_W-1:0] random_glyph();
		string             letters;
		string             digits;
		string             pairs;
		logic [CHAR_W-1:0] c;
		int                pick;
		letters = "ABCDEFGHIJKLMNOPQRSTUVWXYZ";
		digits  = "0123456789";
		pairs   = "KMW";
		pick    = $urandom_range(0, 9);
		if (pick <= 4 || pick == 9)
			c = letters[$urandom_range(0, 25)];
		else if (pick == 5)
			c = pairs[$urandom_range(0, 2)];
		else if (pick <= 7)
			return digits[$urandom_range(0, 9)];
		else
			return CHAR_SPACE;
		if ($urandom_range(0, 1))
			c = c | LOWER_BIT;
		return c;
	endfunction

	initial begin
		wr_bus.ready = 1'b0;
		wait (arst_n);
		forever begin : sink_loop
			int stall;
			stall     = (sink_hold != 0) ? sink_hold : $urandom_range(0, sink_idle_max);
			sink_hold = 0;
			repeat (stall) begin
				@(negedge clk);
				wr_bus.ready = 1'b0;
			end
			@(negedge clk);
			wr_bus.ready = 1'b1;
			do @(posedge clk); while (!wr_bus.valid);
		end
	end

	initial begin
		#2000000;
		$display("end of test: mismatches");
		$finish;
	end

	initial begin : stimulus
		int len;
		int i;
		int waited;
		chr_bus.valid     = 1'b0;
		chr_bus.char_code = '0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// control codes, both cases, digits, two-cell letters, overflow
		send_char(8'h00);
		send_char(8'hff);
		send_char(CHAR_CR);
		send_text("Az09 kMwBK");
		send_char(CHAR_LF);
		// second cell of the final W lands on a full display
		send_text("lNoPqRsTuVW");
		drain_writes();

		// long output hold while characters keep coming
		sink_idle_max = 0;
		src_idle_max  = 0;
		sink_hold     = HOLD_LEN;
		send_char(CHAR_CR);
		for (i = 0; i < 14; i++)
			send_char(random_glyph());
		send_char(CHAR_LF);
		drain_writes();

		while (line_items < LINE_ITEMS) begin
			src_idle_max  = ($urandom_range(0, 3) == 0) ? 0 : 10;
			sink_idle_max = ($urandom_range(0, 3) == 0) ? 0 : 10;
			if ($urandom_range(0, 9) == 0) begin
				repeat ($urandom_range(1, 4))
					send_char(CHAR_W'($urandom_range(0, 255)));
			end
			len = $urandom_range(0, 14);
			for (i = 0; i < len; i++) begin
				send_char(random_glyph());
				line_items++;
				if ($urandom_range(0, 24) == 0)
					send_char(CHAR_W'($urandom_range(0, 255)));
			end
			send_char(($urandom_range(0, 2) == 0) ? CHAR_CR : CHAR_LF);
			line_items++;
			if ($urandom_range(0, 5) == 0)
				drain_writes();
		end

		@(negedge clk);
		chr_bus.valid = 1'b0;
		waited = 0;
		while (pending != 0 && waited < 5000) begin
			@(posedge clk);
			waited++;
		end
		repeat (30) @(posedge clk);
		if (pending != 0)
			$error("%0d expected write beats never arrived", pending);
		$display("Covered %0d character beats (%0d in random lines) and %0d write beats,",
			chars_seen, line_items, writes_seen);
		$display("with display overflow, noise bytes and a %0d-cycle output hold.", HOLD_LEN);
		if (fail_count == 0 && pending == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule
